// ===== hdl/kcl_pkg.sv =====
package kcl_pkg;

  localparam int unsigned CodeLength = 4;
  localparam int unsigned CountW     = 3;
  localparam int unsigned TriesW     = 3;
  localparam int unsigned TimerW     = 8;
  localparam int unsigned CfgDataW   = 8;

  localparam logic [CodeLength-1:0] StoredCodeRst   = '0;
  localparam logic [TriesW-1:0]     MaxAttemptsRst  = 3'd3;
  localparam logic [TimerW-1:0]     IdleTimeoutRst  = 8'd10;
  localparam logic [TimerW-1:0]     LockoutTicksRst = 8'd60;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_KEY   = 2'd2
  } kcl_func_e;

  typedef enum logic [2:0] {
    STAT_IDLE    = 3'd0,
    STAT_DIGIT   = 3'd1,
    STAT_SUCCESS = 3'd2,
    STAT_WRONG   = 3'd3,
    STAT_BLOCKED = 3'd4,
    STAT_TIMEOUT = 3'd5
  } kcl_status_e;

  typedef enum logic [1:0] {
    REG_STORED_CODE   = 2'd0,
    REG_MAX_ATTEMPTS  = 2'd1,
    REG_IDLE_TIMEOUT  = 2'd2,
    REG_LOCKOUT_TICKS = 2'd3
  } kcl_reg_e;

  typedef struct packed {
    kcl_func_e func;
    logic      key_bit;
  } kcl_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [CountW-1:0] digits_entered;
    logic [TriesW-1:0] tries_left;
    logic [TimerW-1:0] block_left;
    logic              is_blocked;
  } kcl_out_t;

  typedef struct packed {
    kcl_reg_e            index;
    logic [CfgDataW-1:0] data;
  } kcl_cfg_t;

endpackage

// ===== hdl/kcl_if.sv =====
interface kcl_in_if;
  logic            valid;
  logic            ready;
  kcl_pkg::kcl_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kcl_out_if;
  logic             valid;
  logic             ready;
  kcl_pkg::kcl_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kcl_cfg_if;
  logic             valid;
  logic             ready;
  kcl_pkg::kcl_cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/keypad_code_lock_with_lockout_unit.sv =====
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless the output stalls; the single state
// update sits between the request handshake and the output register.
// The output register lets a new request in whenever it is empty or drained.
// Reset: registers take their documented defaults, the session starts timed
// out, the output register is empty.
module keypad_code_lock_with_lockout_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  kcl_cfg_if.sink   cfg_i,
  kcl_in_if.sink    in_i,
  kcl_out_if.source out_o
);
  import kcl_pkg::*;

  logic [CodeLength-1:0] stored_code_q;
  logic [TriesW-1:0]     max_attempts_q;
  logic [TimerW-1:0]     idle_timeout_q;
  logic [TimerW-1:0]     lockout_ticks_q;

  logic [CountW-1:0]     dcnt_q, dcnt_d;
  logic [CodeLength-1:0] entry_q, entry_d;
  logic [TriesW-1:0]     tries_q, tries_d;
  logic [TimerW-1:0]     idle_q, idle_d;
  logic [TimerW-1:0]     bcnt_q, bcnt_d;
  logic                  blk_q, blk_d;
  logic                  gr_q, gr_d;

  logic                  out_valid_q, out_valid_d;
  kcl_out_t              out_data_q, out_data_d;
  kcl_status_e           status;
  logic [CountW-1:0]     dcnt_inc;
  logic                  accept;

  function automatic kcl_status_e status_of(logic blk, logic gr, logic [TimerW-1:0] idle);
    kcl_status_e s;
    priority if (blk) s = STAT_BLOCKED;
    else if (gr) s = STAT_SUCCESS;
    else if (idle == '0) s = STAT_TIMEOUT;
    else s = STAT_IDLE;
    return s;
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_code_q   <= StoredCodeRst;
      max_attempts_q  <= MaxAttemptsRst;
      idle_timeout_q  <= IdleTimeoutRst;
      lockout_ticks_q <= LockoutTicksRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_STORED_CODE:   stored_code_q   <= cfg_i.data.data[CodeLength-1:0];
        REG_MAX_ATTEMPTS:  max_attempts_q  <= cfg_i.data.data[TriesW-1:0];
        REG_IDLE_TIMEOUT:  idle_timeout_q  <= cfg_i.data.data[TimerW-1:0];
        REG_LOCKOUT_TICKS: lockout_ticks_q <= cfg_i.data.data[TimerW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign dcnt_inc   = dcnt_q + 1'b1;

  always_comb begin
    dcnt_d  = dcnt_q;
    entry_d = entry_q;
    tries_d = tries_q;
    idle_d  = idle_q;
    bcnt_d  = bcnt_q;
    blk_d   = blk_q;
    gr_d    = gr_q;
    status  = STAT_IDLE;
    unique case (in_i.data.func)
      FUNC_START: begin
        if (!blk_q) begin
          dcnt_d  = '0;
          entry_d = '0;
          tries_d = max_attempts_q;
          idle_d  = idle_timeout_q;
          gr_d    = 1'b0;
        end
        status = status_of(blk_d, gr_d, idle_d);
      end
      FUNC_TICK: begin
        if (blk_q) begin
          if (bcnt_q <= 8'd1) begin
            bcnt_d  = '0;
            blk_d   = 1'b0;
            tries_d = max_attempts_q;
            dcnt_d  = '0;
            entry_d = '0;
            idle_d  = idle_timeout_q;
          end else begin
            bcnt_d = bcnt_q - 1'b1;
          end
        end else if (!gr_q && idle_q != '0) begin
          idle_d = idle_q - 1'b1;
        end
        status = status_of(blk_d, gr_d, idle_d);
      end
      FUNC_KEY: begin
        if (blk_q || gr_q || idle_q == '0) begin
          status = status_of(blk_q, gr_q, idle_q);
        end else begin
          entry_d = {entry_q[CodeLength-2:0], in_i.data.key_bit};
          dcnt_d  = dcnt_inc;
          idle_d  = idle_timeout_q;
          status  = STAT_DIGIT;
          if (dcnt_inc >= CountW'(CodeLength)) begin
            if (entry_d == stored_code_q) begin
              gr_d   = 1'b1;
              dcnt_d = CountW'(CodeLength);
              status = STAT_SUCCESS;
            end else begin
              dcnt_d  = '0;
              entry_d = '0;
              if (tries_q <= 3'd1) begin
                tries_d = '0;
                blk_d   = 1'b1;
                bcnt_d  = lockout_ticks_q;
                status  = STAT_BLOCKED;
              end else begin
                tries_d = tries_q - 1'b1;
                status  = STAT_WRONG;
              end
            end
          end
        end
      end
      default: begin
        status = status_of(blk_q, gr_q, idle_q);
      end
    endcase

    out_data_d.status         = status;
    out_data_d.digits_entered = dcnt_d;
    out_data_d.tries_left     = tries_d;
    out_data_d.block_left     = blk_d ? bcnt_d : '0;
    out_data_d.is_blocked     = blk_d;
  end

  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q      <= '0;
      entry_q     <= '0;
      tries_q     <= '0;
      idle_q      <= '0;
      bcnt_q      <= '0;
      blk_q       <= 1'b0;
      gr_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        dcnt_q  <= dcnt_d;
        entry_q <= entry_d;
        tries_q <= tries_d;
        idle_q  <= idle_d;
        bcnt_q  <= bcnt_d;
        blk_q   <= blk_d;
        gr_q    <= gr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== hdl/kcl_checker.sv =====
module kcl_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input kcl_pkg::kcl_out_t out_data_i
);
  import kcl_pkg::*;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted request produced no result");

  a_blocked_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_data_i.status == STAT_BLOCKED) == out_data_i.is_blocked))
    else $error("blocked status and blocked flag disagree");

  a_block_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.is_blocked || out_data_i.block_left == '0) &&
                    (!out_data_i.is_blocked || out_data_i.tries_left == '0))
    else $error("lockout fields inconsistent");

  a_success_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == STAT_SUCCESS |->
      out_data_i.digits_entered == CountW'(CodeLength))
    else $error("success without a full entry");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result dropped or changed");

endmodule

bind keypad_code_lock_with_lockout_unit kcl_checker u_kcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
